### src/pha_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// pha_pkg
// Shared constants for the point heading angle pipeline: angle scaling,
// CORDIC arctangent table, rounding constants and sector thresholds.
// ============================================================================
package pha_pkg;

    // Defaults for the top level parameters
    localparam int DEF_CORDIC_STEPS = 16;
    localparam int DEF_COORD_BITS   = 32;

    // Datapath widths
    localparam int ANG_W    = 35;   // angle, radians scaled by 2^30, signed
    localparam int CORDIC_W = 57;   // CORDIC x/y after normalization, signed
    localparam int NORM_MSB = 52;   // larger component lands in [2^52, 2^53)
    localparam int TABLE_LEN = 24;

    // Angle constants in radians * 2^30
    localparam longint PI_L = 64'sd3373259426;
    localparam logic signed [ANG_W-1:0] PI_A30      = ANG_W'(PI_L);
    localparam logic signed [ANG_W-1:0] TWO_PI_A30  = ANG_W'(2 * PI_L);
    localparam logic signed [ANG_W-1:0] HALF_PI_A30 = ANG_W'(PI_L / 2);
    localparam logic signed [ANG_W-1:0] PI8_A30     = ANG_W'(PI_L / 8);
    localparam logic [31:0]             PI_U        = 32'(PI_L);

    // Radians output: round half up from 2^30 to 2^13 scaling
    localparam int RAD_SHIFT = 17;
    localparam logic signed [ANG_W-1:0] RAD_ROUND = ANG_W'(64'sd1 <<< (RAD_SHIFT - 1));
    localparam logic signed [15:0]      RAD_LIMIT = 16'sd25736;

    // Degrees output: 180 * 2^6 per PI, quotient by reciprocal multiply
    localparam logic [13:0]        DEG_SCALE       = 14'd11520;
    localparam logic signed [15:0] DEG_LIMIT       = 16'sd11520;
    localparam int                 DEG_N_W         = 46;
    localparam int                 DEG_PRE_SHIFT   = 14;
    localparam int                 DEG_RECIP_SHIFT = 34;
    localparam int                 DEG_Q_W         = 14;
    localparam logic [16:0]        DEG_RECIP       =
        17'((64'sd1 <<< (DEG_RECIP_SHIFT + DEG_PRE_SHIFT)) / PI_L);

    // Sector k starts at ceil(k * PI / 4) of the flipped, offset angle
    localparam logic signed [ANG_W-1:0] SEC_TH [7] = '{
        ANG_W'((1 * PI_L + 3) / 4), ANG_W'((2 * PI_L + 3) / 4),
        ANG_W'((3 * PI_L + 3) / 4), ANG_W'((4 * PI_L + 3) / 4),
        ANG_W'((5 * PI_L + 3) / 4), ANG_W'((6 * PI_L + 3) / 4),
        ANG_W'((7 * PI_L + 3) / 4)
    };

    // atan(2^-i) * 2^30, truncated
    localparam logic signed [ANG_W-1:0] ATAN_TAB [TABLE_LEN] = '{
        35'sd843314856, 35'sd497837829, 35'sd263043836, 35'sd133525158,
        35'sd67021686,  35'sd33543515,  35'sd16775850,  35'sd8388437,
        35'sd4194282,   35'sd2097149,   35'sd1048575,   35'sd524287,
        35'sd262143,    35'sd131071,    35'sd65535,     35'sd32767,
        35'sd16383,     35'sd8191,      35'sd4095,      35'sd2047,
        35'sd1023,      35'sd511,       35'sd255,       35'sd127
    };

endpackage

### src/point_heading_angle.sv
`timescale 1ns / 1ps
// ============================================================================
// point_heading_angle
// Heading of the vector from point A to point B in radians, degrees and an
// eight-way compass sector, computed by a fully pipelined vectoring CORDIC.
// ============================================================================
//
// Usage:
//   Request channel (point_valid / point_ready) carries two points as
//   signed coordinates with 8 fraction bits. Result channel (heading_valid /
//   heading_ready) returns one heading per request, in request order.
//   The heading is atan2(dx, -dy) in [-PI, PI); a zero vector or dx zero
//   with dy positive gives -PI.
//
//   A request passes the difference, normalizer, fold, CORDIC, P1 to P4 and
//   output register stages in order to heading_valid. Throughput: one
//   request per cycle when nothing stalls; each CORDIC micro-rotation, the
//   two normalizer stages and the degree divider steps each own a stage.
//
//   Every stage carries its own valid bit and advances whenever it is empty
//   or the stage after it advances, so bubbles collapse and requests keep
//   entering while a finished result waits at the output register.
//   When the receiver stalls the output holds and the stages fill up;
//   point_ready drops only once all stages are occupied.
//
//   Reset clears all valid bits; the data registers are not reset.
// ============================================================================
module point_heading_angle #(
    parameter int CORDIC_STEPS = pha_pkg::DEF_CORDIC_STEPS,
    parameter int COORD_BITS   = pha_pkg::DEF_COORD_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         point_valid,
    output logic                         point_ready,
    input  logic signed [COORD_BITS-1:0] point_a_x,
    input  logic signed [COORD_BITS-1:0] point_a_y,
    input  logic signed [COORD_BITS-1:0] point_b_x,
    input  logic signed [COORD_BITS-1:0] point_b_y,

    output logic                         heading_valid,
    input  logic                         heading_ready,
    output logic signed [15:0]           heading_radians,
    output logic signed [14:0]           heading_degrees,
    output logic [2:0]                   compass_sector
);

    localparam int DW  = COORD_BITS + 1;
    localparam int CW  = pha_pkg::CORDIC_W;
    localparam int AW  = pha_pkg::ANG_W;
    localparam int NW  = pha_pkg::DEG_N_W;
    localparam int QW  = pha_pkg::DEG_Q_W;
    localparam int NS  = CORDIC_STEPS + 9;

    // Stage indices
    localparam int ST_CR0 = 4;
    localparam int ST_P1  = CORDIC_STEPS + 4;   // wrap and special cases
    localparam int ST_P2  = CORDIC_STEPS + 5;   // radians, degree numerator
    localparam int ST_P3  = CORDIC_STEPS + 6;   // quotient estimate
    localparam int ST_P4  = CORDIC_STEPS + 7;   // remainder
    localparam int ST_OUT = CORDIC_STEPS + 8;   // output register

    // ------------------------------------------------------------------
    // Valid bits and per-stage flow control
    // ------------------------------------------------------------------
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vld_next;
    logic [NS-1:0] vin;
    logic [NS:0]   rdy;
    logic [NS-1:0] en;

    assign vin     = {vld_reg[NS-2:0], point_valid};
    assign rdy[NS] = heading_ready;

    // A stage takes new data when it is empty or its contents move on
    for (genvar i = 0; i < NS; i++)
    begin : g_rdy
        assign rdy[i] = ~vld_reg[i] | rdy[i+1];
    end

    assign en = rdy[NS-1:0] & vin;

    always_comb
    begin
        for (int i = 0; i < NS; i++)
        begin
            vld_next[i] = rdy[i] ? vin[i] : vld_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign point_ready   = rdy[0];
    assign heading_valid = vld_reg[ST_OUT];

    // ------------------------------------------------------------------
    // Stage 0: coordinate differences
    // ------------------------------------------------------------------
    logic signed [DW-1:0] dx_reg, dy_reg;
    logic signed [DW-1:0] dx_next, dy_next;

    always_comb
    begin
        dx_next = DW'(point_b_x) - DW'(point_a_x);
        dy_next = DW'(point_b_y) - DW'(point_a_y);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
    end

    // Special-case flags travel with the item down to the wrap stage
    logic [CORDIC_STEPS+2:0] zx_reg;   // dx is zero
    logic [CORDIC_STEPS+2:0] ny_reg;   // dy is negative

    // ------------------------------------------------------------------
    // Stage 1: rotate into CORDIC frame (x = -dy, y = dx), coarse normalize
    // ------------------------------------------------------------------
    logic signed [CW-1:0] xa_reg, ya_reg;
    logic signed [CW-1:0] xa_next, ya_next;
    logic                 zx_next, ny_next;

    always_comb
    begin
        logic [CW-1:0] m;
        xa_next = -CW'(dy_reg);
        ya_next = CW'(dx_reg);
        m = (xa_next[CW-1] ? -xa_next : xa_next) | (ya_next[CW-1] ? -ya_next : ya_next);
        // Advance by 32 and 16 while the larger magnitude stays below 2^53
        if ((m >> (pha_pkg::NORM_MSB + 1 - 32)) == '0)
        begin
            m       = m << 32;
            xa_next = xa_next <<< 32;
            ya_next = ya_next <<< 32;
        end
        if ((m >> (pha_pkg::NORM_MSB + 1 - 16)) == '0)
        begin
            xa_next = xa_next <<< 16;
            ya_next = ya_next <<< 16;
        end
        zx_next = (dx_reg == '0);
        ny_next = dy_reg[DW-1];
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            xa_reg <= xa_next;
            ya_reg <= ya_next;
        end
    end

    // Flags enter with stage 1 and shift along with their stages
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            zx_reg[0] <= zx_next;
            ny_reg[0] <= ny_next;
        end
        for (int k = 1; k <= CORDIC_STEPS + 2; k++)
        begin
            if (en[k+1])
            begin
                zx_reg[k] <= zx_reg[k-1];
                ny_reg[k] <= ny_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: fine normalize (8, 4, 2, 1)
    // ------------------------------------------------------------------
    logic signed [CW-1:0] xb_reg, yb_reg;
    logic signed [CW-1:0] xb_next, yb_next;

    always_comb
    begin
        logic [CW-1:0] m;
        xb_next = xa_reg;
        yb_next = ya_reg;
        m = (xb_next[CW-1] ? -xb_next : xb_next) | (yb_next[CW-1] ? -yb_next : yb_next);
        if ((m >> (pha_pkg::NORM_MSB + 1 - 8)) == '0)
        begin
            m = m << 8; xb_next = xb_next <<< 8; yb_next = yb_next <<< 8;
        end
        if ((m >> (pha_pkg::NORM_MSB + 1 - 4)) == '0)
        begin
            m = m << 4; xb_next = xb_next <<< 4; yb_next = yb_next <<< 4;
        end
        if ((m >> (pha_pkg::NORM_MSB + 1 - 2)) == '0)
        begin
            m = m << 2; xb_next = xb_next <<< 2; yb_next = yb_next <<< 2;
        end
        if ((m >> (pha_pkg::NORM_MSB + 1 - 1)) == '0)
        begin
            xb_next = xb_next <<< 1; yb_next = yb_next <<< 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            xb_reg <= xb_next;
            yb_reg <= yb_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: fold the left half-plane into the right one
    // ------------------------------------------------------------------
    logic signed [CW-1:0] cx_reg [CORDIC_STEPS+1];
    logic signed [CW-1:0] cy_reg [CORDIC_STEPS+1];
    logic signed [AW-1:0] ca_reg [CORDIC_STEPS+1];
    logic signed [CW-1:0] cx_next, cy_next;
    logic signed [AW-1:0] ca_next;

    always_comb
    begin
        cx_next = xb_reg;
        cy_next = yb_reg;
        ca_next = '0;
        if (xb_reg[CW-1])
        begin
            if (!yb_reg[CW-1])
            begin
                cx_next = yb_reg;
                cy_next = -xb_reg;
                ca_next = pha_pkg::HALF_PI_A30;
            end
            else
            begin
                cx_next = -yb_reg;
                cy_next = xb_reg;
                ca_next = -pha_pkg::HALF_PI_A30;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            cx_reg[0] <= cx_next;
            cy_reg[0] <= cy_next;
            ca_reg[0] <= ca_next;
        end
    end

    // ------------------------------------------------------------------
    // CORDIC micro-rotations, one per stage: drive y toward zero
    // ------------------------------------------------------------------
    for (genvar j = 0; j < CORDIC_STEPS; j++)
    begin : g_cordic
        logic signed [CW-1:0] xs, ys, x_next, y_next;
        logic signed [AW-1:0] a_next;

        always_comb
        begin
            xs = cx_reg[j] >>> j;
            ys = cy_reg[j] >>> j;
            if (!cy_reg[j][CW-1] && (cy_reg[j] != '0))
            begin
                x_next = cx_reg[j] + ys;
                y_next = cy_reg[j] - xs;
                a_next = ca_reg[j] + pha_pkg::ATAN_TAB[j];
            end
            else
            begin
                x_next = cx_reg[j] - ys;
                y_next = cy_reg[j] + xs;
                a_next = ca_reg[j] - pha_pkg::ATAN_TAB[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[ST_CR0+j])
            begin
                cx_reg[j+1] <= x_next;
                cy_reg[j+1] <= y_next;
                ca_reg[j+1] <= a_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // P1: wrap into [-PI, PI), apply the dx-zero headings
    // ------------------------------------------------------------------
    logic signed [AW-1:0] ang_reg, ang_next;

    always_comb
    begin
        ang_next = ca_reg[CORDIC_STEPS];
        if (ang_next >= pha_pkg::PI_A30)
        begin
            ang_next = ang_next - pha_pkg::TWO_PI_A30;
        end
        if (ang_next < -pha_pkg::PI_A30)
        begin
            ang_next = ang_next + pha_pkg::TWO_PI_A30;
        end
        if (zx_reg[CORDIC_STEPS+2])
        begin
            ang_next = ny_reg[CORDIC_STEPS+2] ? '0 : -pha_pkg::PI_A30;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_P1])
        begin
            ang_reg <= ang_next;
        end
    end

    // ------------------------------------------------------------------
    // P2: radians, degree numerator, sector
    // ------------------------------------------------------------------
    logic signed [15:0] rad2_reg, rad2_next;
    logic [NW-1:0]      n2_reg, n2_next;
    logic               neg2_reg;
    logic [2:0]         sec2_reg, sec2_next;

    always_comb
    begin
        logic signed [AW-1:0] rad_full;
        logic [31:0]          mag;
        logic signed [AW-1:0] v0;
        rad_full = (ang_reg + pha_pkg::RAD_ROUND) >>> pha_pkg::RAD_SHIFT;
        if (rad_full >= AW'(pha_pkg::RAD_LIMIT))
        begin
            rad2_next = -pha_pkg::RAD_LIMIT;
        end
        else
        begin
            rad2_next = 16'(rad_full);
        end

        mag     = 32'(ang_reg[AW-1] ? -ang_reg : ang_reg);
        n2_next = NW'(mag * pha_pkg::DEG_SCALE) + NW'(pha_pkg::HALF_PI_A30);

        // Flip and offset by PI/8; an offset past 2PI wraps into sector zero
        if (ang_reg[AW-1])
        begin
            v0 = pha_pkg::PI8_A30 - ang_reg;
        end
        else
        begin
            v0 = pha_pkg::TWO_PI_A30 + pha_pkg::PI8_A30 - ang_reg;
        end
        sec2_next = '0;
        for (int k = 0; k < 7; k++)
        begin
            sec2_next = sec2_next + 3'(v0 >= pha_pkg::SEC_TH[k]);
        end
        if (v0 >= pha_pkg::TWO_PI_A30)
        begin
            sec2_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_P2])
        begin
            rad2_reg <= rad2_next;
            n2_reg   <= n2_next;
            neg2_reg <= ang_reg[AW-1];
            sec2_reg <= sec2_next;
        end
    end

    // ------------------------------------------------------------------
    // P3: quotient estimate by reciprocal, never above the true quotient
    // ------------------------------------------------------------------
    logic signed [15:0] rad3_reg;
    logic [NW-1:0]      n3_reg;
    logic               neg3_reg;
    logic [2:0]         sec3_reg;
    logic [QW-1:0]      q3_reg, q3_next;

    always_comb
    begin
        logic [48:0] qp;
        qp      = 49'(n2_reg[NW-1:pha_pkg::DEG_PRE_SHIFT] * pha_pkg::DEG_RECIP);
        q3_next = qp[pha_pkg::DEG_RECIP_SHIFT +: QW];
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_P3])
        begin
            rad3_reg <= rad2_reg;
            n3_reg   <= n2_reg;
            neg3_reg <= neg2_reg;
            sec3_reg <= sec2_reg;
            q3_reg   <= q3_next;
        end
    end

    // ------------------------------------------------------------------
    // P4: remainder against the estimate
    // ------------------------------------------------------------------
    logic signed [15:0] rad4_reg;
    logic               neg4_reg;
    logic [2:0]         sec4_reg;
    logic [QW-1:0]      q4_reg;
    logic [33:0]        r4_reg, r4_next;

    always_comb
    begin
        logic [NW-1:0] prod;
        prod    = NW'(q3_reg * pha_pkg::PI_U);
        r4_next = 34'(n3_reg - prod);
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_P4])
        begin
            rad4_reg <= rad3_reg;
            neg4_reg <= neg3_reg;
            sec4_reg <= sec3_reg;
            q4_reg   <= q3_reg;
            r4_reg   <= r4_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register: correct quotient, apply sign, fold +PI onto -PI
    // ------------------------------------------------------------------
    logic signed [15:0] rad_out_reg;
    logic signed [14:0] deg_out_reg, deg_out_next;
    logic [2:0]         sec_out_reg;

    always_comb
    begin
        logic [QW:0]        q;
        logic signed [15:0] deg;
        q   = {1'b0, q4_reg} + (QW+1)'(r4_reg >= 34'(pha_pkg::PI_U));
        deg = neg4_reg ? -$signed(16'(q)) : $signed(16'(q));
        if (deg >= pha_pkg::DEG_LIMIT)
        begin
            deg = -pha_pkg::DEG_LIMIT;
        end
        deg_out_next = 15'(deg);
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
        begin
            rad_out_reg <= rad4_reg;
            deg_out_reg <= deg_out_next;
            sec_out_reg <= sec4_reg;
        end
    end

    assign heading_radians = rad_out_reg;
    assign heading_degrees = deg_out_reg;
    assign compass_sector  = sec_out_reg;

`ifndef ASSERT_OFF
    // An accepted request always lands in the first stage
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && point_ready |=> vld_reg[0])
        else $error("accepted request did not enter the pipeline");

    // A stage blocked by its successor keeps its item
    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_P4] && !rdy[ST_P4] |=> vld_reg[ST_P4])
        else $error("stalled item dropped from remainder stage");

    // After normalization the larger component reaches 2^52
    a_norm_reached: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[2] && !zx_reg[1] |->
            (xb_reg >= (CW'(1) <<< pha_pkg::NORM_MSB)) ||
            (xb_reg <= -(CW'(1) <<< pha_pkg::NORM_MSB)) ||
            (yb_reg >= (CW'(1) <<< pha_pkg::NORM_MSB)) ||
            (yb_reg <= -(CW'(1) <<< pha_pkg::NORM_MSB)))
        else $error("normalizer left the vector short of range");

    // Quotient estimate is low by at most one
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_P4] |-> r4_reg < (34'(pha_pkg::PI_U) << 1))
        else $error("degree remainder out of range");
`endif

endmodule

### sim/heading_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// heading_checker
// Watches the point and heading channels of the heading pipeline. It predicts
// each heading from the accepted points with a bit-exact CORDIC of its own
// and compares every returned field with the oldest heading still owed.
// ============================================================================
module heading_checker (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               point_valid,
    input  logic               point_ready,
    input  logic signed [31:0] point_a_x,
    input  logic signed [31:0] point_a_y,
    input  logic signed [31:0] point_b_x,
    input  logic signed [31:0] point_b_y,

    input  logic               heading_valid,
    input  logic               heading_ready,
    input  logic signed [15:0] heading_radians,
    input  logic signed [14:0] heading_degrees,
    input  logic [2:0]         compass_sector,

    output int                 mismatch_count,
    output int                 headings_owed
);

    typedef struct {
        logic signed [15:0] radians;
        logic signed [14:0] degrees;
        logic [2:0]         sector;
    } heading_t;

    // Angles are radians scaled by 2^30
    localparam longint PI_Q30        = 64'sd3373259426;
    localparam longint TWO_PI_Q30    = 2 * PI_Q30;
    localparam longint HALF_PI_Q30   = PI_Q30 / 2;
    localparam longint EIGHTH_PI_Q30 = PI_Q30 / 8;
    localparam longint NORM_TOP      = 64'sd1 <<< 52;
    localparam int     ROT_STEPS     = 16;
    localparam int     PRINT_CAP     = 40;

    // atan(2^-i) in the same scaling, truncated
    localparam longint ATAN_STEP [ROT_STEPS] = '{
        64'sd843314856, 64'sd497837829, 64'sd263043836, 64'sd133525158,
        64'sd67021686,  64'sd33543515,  64'sd16775850,  64'sd8388437,
        64'sd4194282,   64'sd2097149,   64'sd1048575,   64'sd524287,
        64'sd262143,    64'sd131071,    64'sd65535,     64'sd32767
    };

    heading_t heading_queue [$];
    heading_t owed_heading;

    initial begin
        mismatch_count = 0;
        headings_owed  = 0;
    end

    function automatic heading_t compute_heading(
        input logic signed [31:0] ax,
        input logic signed [31:0] ay,
        input logic signed [31:0] bx,
        input logic signed [31:0] by
    );
        longint   dx, dy, vx, vy, swap, sx, sy;
        longint   ang, rad, deg, num, turn, flip, sec;
        int       step;
        heading_t h;

        dx = longint'(bx) - longint'(ax);
        dy = longint'(by) - longint'(ay);

        if (dx == 0) begin
            ang = (dy < 0) ? 64'sd0 : -PI_Q30;
        end
        else begin
            // vectoring on (-dy, dx); scale up so the shifts keep precision
            vx = -dy;
            vy = dx;
            while ((vx < 0 ? -vx : vx) < NORM_TOP && (vy < 0 ? -vy : vy) < NORM_TOP)
            begin
                vx = vx * 2;
                vy = vy * 2;
            end
            ang = 0;
            if (vx < 0) begin
                swap = vx;
                if (vy >= 0) begin
                    vx  = vy;
                    vy  = -swap;
                    ang = HALF_PI_Q30;
                end
                else begin
                    vx  = -vy;
                    vy  = swap;
                    ang = -HALF_PI_Q30;
                end
            end
            for (step = 0; step < ROT_STEPS; step++) begin
                sx = vx >>> step;
                sy = vy >>> step;
                if (vy > 0) begin
                    vx  = vx + sy;
                    vy  = vy - sx;
                    ang = ang + ATAN_STEP[step];
                end
                else begin
                    vx  = vx - sy;
                    vy  = vy + sx;
                    ang = ang - ATAN_STEP[step];
                end
            end
            if (ang >= PI_Q30)
                ang = ang - TWO_PI_Q30;
            if (ang < -PI_Q30)
                ang = ang + TWO_PI_Q30;
        end

        // round half up, and fold +PI back onto -PI
        rad = (ang + 64'sd65536) >>> 17;
        if (rad >= 25736)
            rad = -25736;

        // round half away from zero
        num = ang * 11520;
        if (num >= 0)
            deg = (num + HALF_PI_Q30) / PI_Q30;
        else
            deg = -((-num + HALF_PI_Q30) / PI_Q30);
        if (deg >= 11520)
            deg = -11520;

        turn = (ang < 0) ? ang + TWO_PI_Q30 : ang;
        flip = TWO_PI_Q30 - turn + EIGHTH_PI_Q30;
        if (flip >= TWO_PI_Q30)
            flip = flip - TWO_PI_Q30;
        sec = (flip * 4) / PI_Q30;
        if (sec > 7)
            sec = 7;

        h.radians = 16'(rad);
        h.degrees = 15'(deg);
        h.sector  = 3'(sec);
        return h;
    endfunction

    task automatic report_error(input string msg);
        if (mismatch_count < PRINT_CAP)
            $display("[%0t] heading check: %s", $realtime, msg);
        mismatch_count++;
    endtask

    always @(posedge clk) begin
        if (rst_n) begin
            if (heading_valid && heading_ready) begin
                if (heading_queue.size() == 0) begin
                    report_error($sformatf("heading with no request waiting (rad %0d)",
                                           heading_radians));
                end
                else begin
                    owed_heading = heading_queue.pop_front();
                    if (heading_radians !== owed_heading.radians)
                        report_error($sformatf("radians got %0d want %0d",
                                               heading_radians, owed_heading.radians));
                    if (heading_degrees !== owed_heading.degrees)
                        report_error($sformatf("degrees got %0d want %0d",
                                               heading_degrees, owed_heading.degrees));
                    if (compass_sector !== owed_heading.sector)
                        report_error($sformatf("sector got %0d want %0d",
                                               compass_sector, owed_heading.sector));
                end
            end
            if (point_valid && point_ready)
                heading_queue.push_back(compute_heading(point_a_x, point_a_y,
                                                        point_b_x, point_b_y));
            headings_owed <= heading_queue.size();
        end
    end

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Drives point pairs into the heading pipeline and pulls headings out, with
// random idling on both channels, a long receiver hold-off and a full drain.
// The checker beside the block predicts and compares; this module only makes
// stimulus and gives the verdict.
// ============================================================================
module testbench;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 11;
    localparam int LONG_HOLD    = 150;   // well past the pipeline depth
    localparam int DRAIN_CYCLES = 40;    // margin past the pipeline depth
    localparam int STALL_LIMIT  = 2000;  // cycles with no handshake at all

    localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;

    logic               point_valid = 1'b0;
    logic               point_ready;
    logic signed [31:0] point_a_x = '0;
    logic signed [31:0] point_a_y = '0;
    logic signed [31:0] point_b_x = '0;
    logic signed [31:0] point_b_y = '0;

    logic               heading_valid;
    logic               heading_ready = 1'b0;
    logic signed [15:0] heading_radians;
    logic signed [14:0] heading_degrees;
    logic [2:0]         compass_sector;

    int                 mismatch_count;
    int                 headings_owed;

    // idling switches, flipped per phase by the stimulus process
    bit                 sender_idle_on   = 1'b1;
    bit                 receiver_idle_on = 1'b1;
    // bump to ask the receiver for one long hold-off
    int                 hold_serial = 0;

    always #(CLK_HALF) clk = ~clk;

    point_heading_angle u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .point_valid     (point_valid),
        .point_ready     (point_ready),
        .point_a_x       (point_a_x),
        .point_a_y       (point_a_y),
        .point_b_x       (point_b_x),
        .point_b_y       (point_b_y),
        .heading_valid   (heading_valid),
        .heading_ready   (heading_ready),
        .heading_radians (heading_radians),
        .heading_degrees (heading_degrees),
        .compass_sector  (compass_sector)
    );

    heading_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .point_valid     (point_valid),
        .point_ready     (point_ready),
        .point_a_x       (point_a_x),
        .point_a_y       (point_a_y),
        .point_b_x       (point_b_x),
        .point_b_y       (point_b_y),
        .heading_valid   (heading_valid),
        .heading_ready   (heading_ready),
        .heading_radians (heading_radians),
        .heading_degrees (heading_degrees),
        .compass_sector  (compass_sector),
        .mismatch_count  (mismatch_count),
        .headings_owed   (headings_owed)
    );

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // Offer one request and hold it until the block takes it. Returns right
    // after the accepting edge, so the next call can keep valid high.
    task automatic offer_point(
        input logic signed [31:0] ax,
        input logic signed [31:0] ay,
        input logic signed [31:0] bx,
        input logic signed [31:0] by
    );
        int gap;

        // drop valid for a short burst now and then
        if (sender_idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 5);
            point_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        point_a_x   <= ax;
        point_a_y   <= ay;
        point_b_x   <= bx;
        point_b_y   <= by;
        point_valid <= 1'b1;
        // ready is sampled as it stood at the edge
        do @(posedge clk); while (!point_ready);
    endtask

    // Pick a random request. Most land in shapes that stress the angle
    // math: tiny vectors, axis-aligned and diagonal ones, vectors hugging
    // the -PI/+PI seam, and extreme corners; the rest are raw random bits.
    task automatic offer_random_point();
        logic signed [31:0] ax, ay, bx, by;
        int                 stretch;

        ax = $urandom;
        ay = $urandom;
        bx = $urandom;
        by = $urandom;
        case ($urandom_range(0, 9))
            4, 5: begin
                bx = ax + ($urandom_range(0, 1024) - 512);
                by = ay + ($urandom_range(0, 1024) - 512);
            end
            6: begin
                if ($urandom_range(0, 1))
                    bx = ax;
                else
                    by = ay;
            end
            7: begin
                stretch = $urandom_range(1, 1 << 20);
                bx = $urandom_range(0, 1) ? ax + stretch : ax - stretch;
                by = $urandom_range(0, 1) ? ay + stretch : ay - stretch;
            end
            8: begin
                bx = ax + ($urandom_range(0, 6) - 3);
                by = ay + $urandom_range(1 << 16, 1 << 30);
            end
            9: begin
                bx = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
                by = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
            end
            default: ;
        endcase
        offer_point(ax, ay, bx, by);
    endtask

    // Stop offering and wait until every heading owed has come back.
    task automatic wait_for_drain();
        point_valid <= 1'b0;
        do @(posedge clk); while (headings_owed != 0);
    endtask

    // ------------------------------------------------------------------------
    // Receiver side: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        int seen_serial;
        int gap;

        seen_serial = 0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (hold_serial != seen_serial) begin
                // hold long enough that every stage fills and the input stalls
                seen_serial = hold_serial;
                heading_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (receiver_idle_on && $urandom_range(0, 6) == 0) begin
                gap = $urandom_range(1, 5);
                heading_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            heading_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if no handshake happens for too long
    // ------------------------------------------------------------------------
    initial begin
        int quiet_cycles;

        quiet_cycles = 0;
        wait (rst_n === 1'b1);
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((point_valid && point_ready) || (heading_valid && heading_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no handshake for %0d cycles, %0d headings owed",
                 STALL_LIMIT, headings_owed);
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus and verdict
    // ------------------------------------------------------------------------
    initial begin
        int chunk;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero vectors, at the origin and elsewhere: heading is -PI
        offer_point(32'sd0, 32'sd0, 32'sd0, 32'sd0);
        offer_point(32'sd12345, -32'sd678, 32'sd12345, -32'sd678);
        offer_point(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        // dx zero: dy positive gives -PI, dy negative gives 0
        offer_point(32'sd0, 32'sd0, 32'sd0, 32'sd256);
        offer_point(32'sd0, 32'sd0, 32'sd0, -32'sd256);
        offer_point(32'sd5, COORD_MIN, 32'sd5, COORD_MAX);
        offer_point(32'sd5, COORD_MAX, 32'sd5, COORD_MIN);
        // dy zero, both signs of dx
        offer_point(32'sd0, 32'sd0, 32'sd256, 32'sd0);
        offer_point(32'sd0, 32'sd0, -32'sd256, 32'sd0);
        // widest differences the coordinates allow
        offer_point(COORD_MIN, 32'sd0, COORD_MAX, 32'sd0);
        offer_point(COORD_MAX, 32'sd0, COORD_MIN, 32'sd0);
        offer_point(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
        offer_point(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
        offer_point(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
        offer_point(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
        // just short of +PI (rounds up and folds to -PI) and just past -PI
        offer_point(32'sd0, 32'sd0, 32'sd1, COORD_MAX);
        offer_point(32'sd0, 32'sd0, -32'sd1, COORD_MAX);
        // hair either side of zero heading
        offer_point(32'sd0, 32'sd0, 32'sd1, -COORD_MAX);
        offer_point(32'sd0, 32'sd0, -32'sd1, -COORD_MAX);
        // diagonals: one per quadrant
        offer_point(32'sd0, 32'sd0, 32'sd256, 32'sd256);
        offer_point(32'sd0, 32'sd0, -32'sd256, 32'sd256);
        offer_point(32'sd0, 32'sd0, 32'sd256, -32'sd256);
        offer_point(32'sd0, 32'sd0, -32'sd256, -32'sd256);
        // a short diagonal step across the origin
        offer_point(-32'sd1, -32'sd1, 32'sd1, 32'sd1);
        wait_for_drain();

        // random requests; every third chunk runs without idling
        for (chunk = 0; chunk < 6; chunk++) begin
            sender_idle_on   = (chunk % 3 != 2);
            receiver_idle_on = (chunk % 3 != 2);
            repeat (100) offer_random_point();
        end

        // long receiver hold-off while requests keep coming
        sender_idle_on = 1'b0;
        hold_serial <= hold_serial + 1;
        repeat (200) offer_random_point();

        // pause the sender until every heading is back
        wait_for_drain();

        sender_idle_on   = 1'b1;
        receiver_idle_on = 1'b1;
        repeat (500) offer_random_point();

        // final stretch at full rate on both sides
        sender_idle_on   = 1'b0;
        receiver_idle_on = 1'b0;
        repeat (300) offer_random_point();

        point_valid <= 1'b0;
        do @(posedge clk); while (headings_owed != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && headings_owed == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### sim.f
src/pha_pkg.sv
src/point_heading_angle.sv
sim/heading_checker.sv
sim/testbench.sv
